// ===== src/assert_macros.svh =====
// Assertion macros for the ramp generator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property with active-low reset masking.
`define SRG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("srg assertion failed");
// Checked property that also holds during reset.
`define SRG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("srg assertion failed");
`else
`define SRG_ASSERT(lbl, clk, rstn, prop)
`define SRG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/srg_pkg.sv =====
package srg_pkg;

    // Field and register widths.
    localparam int TF_W    = 27;
    localparam int SPR_W   = 16;
    localparam int IP_W    = 16;
    localparam int RPM_W   = 20;
    localparam int STEP_W  = 24;
    localparam int NUM_W   = 41;
    localparam int DEN_W   = 36;
    localparam int MOTOR_W = 2;
    localparam int PER_W   = 16;

    // Configuration reset values.
    localparam logic [TF_W-1:0]  TF_RST  = 27'd2048780;
    localparam logic [SPR_W-1:0] SPR_RST = 16'd3200;
    localparam logic [IP_W-1:0]  IP_RST  = 16'd25000;

    // Period limits in whole timer counts.
    localparam logic [IP_W-1:0] NEAR_CNT = 16'd100;
    localparam logic [IP_W-1:0] MIN_CNT  = 16'd11;
    localparam logic [IP_W-1:0] MAX_CNT  = 16'd65535;

    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    // Command codes.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_ENABLE  = 2'd2;
    localparam logic [1:0] CMD_DISABLE = 2'd3;

    // Register indexes.
    localparam logic [1:0] REG_TF   = 2'd0;
    localparam logic [1:0] REG_SPR  = 2'd1;
    localparam logic [1:0] REG_INIT = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [MOTOR_W-1:0]      motor;
        logic signed [RPM_W-1:0] rpm;
    } t_in;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_out;
        logic               timer_run;
        logic [PER_W-1:0]   period;
        logic               dir_level;
        logic               drivers_on;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic commit;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } t_sts;

endpackage

// ===== src/srg_datapath.sv =====
module srg_datapath import srg_pkg::*; #(
    parameter int MOTOR_COUNT = 3,
    parameter int FRAC_BITS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in              i_in_data,
    input  logic             i_out_stall,
    input  logic [TF_W-1:0]  i_timer_freq,
    input  logic [SPR_W-1:0] i_steps_per_rev,
    input  logic [IP_W-1:0]  i_init_period,
    input  t_ctl             i_ctl,
    output t_sts             o_sts,
    output logic             o_out_valid,
    output t_out             o_out_data
);

    localparam int PW  = STEP_W + FRAC_BITS;
    localparam int DVW = NUM_W + FRAC_BITS;
    localparam int RW  = DEN_W + 1;
    localparam int MIW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    // Work modes chosen when an item is prepared.
    localparam logic [2:0] M_NOP  = 3'd0;
    localparam logic [2:0] M_KEEP = 3'd1;
    localparam logic [2:0] M_ACC  = 3'd2;
    localparam logic [2:0] M_DEC  = 3'd3;
    localparam logic [2:0] M_SET  = 3'd4;
    localparam logic [2:0] M_SETZ = 3'd5;
    localparam logic [2:0] M_EN   = 3'd6;
    localparam logic [2:0] M_DIS  = 3'd7;

    // Per-motor state.
    logic [PW-1:0]     r_cur  [MOTOR_COUNT];
    logic [PW-1:0]     r_tgt  [MOTOR_COUNT];
    logic [STEP_W-1:0] r_step [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] r_cdir, r_wdir, r_stop, r_run;
    logic r_en;

    // Item and work registers.
    t_in               r_in;
    logic [2:0]        r_mode;
    logic [PW-1:0]     r_c;
    logic [STEP_W-1:0] r_s;
    logic              r_run_w;
    logic              r_dir_w;
    logic [DEN_W-1:0]  r_den;
    logic [RW-1:0]     r_rem;
    logic [DVW-1:0]    r_quo;
    logic              r_out_valid;
    t_out              r_out;

    logic           m_ok;
    logic [MIW-1:0] idx;
    logic [PW-1:0]  init_fx, near_fx, min_fx, max_fx;

    assign m_ok    = (int'(r_in.motor) < MOTOR_COUNT);
    assign idx     = MIW'(r_in.motor);
    assign init_fx = PW'(i_init_period) << FRAC_BITS;
    assign near_fx = PW'(NEAR_CNT) << FRAC_BITS;
    assign min_fx  = PW'(MIN_CNT) << FRAC_BITS;
    assign max_fx  = PW'(MAX_CNT) << FRAC_BITS;

    // Preparation: choose the mode and load the divider operands.
    logic [2:0]        p_mode;
    logic [PW-1:0]     p_c, p_c0, p_c1;
    logic [STEP_W-1:0] p_s, p_s0, p_s1, p_s2;
    logic              p_run, p_dir;
    logic [DEN_W-1:0]  p_den;
    logic [DVW-1:0]    p_dvd;
    logic [RPM_W-1:0]  p_mag;
    logic [NUM_W-1:0]  p_num;

    always_comb begin
        p_mode = M_NOP;
        p_c0   = r_cur[idx];
        p_s0   = r_step[idx];
        p_run  = r_run[idx];
        p_dir  = r_cdir[idx];
        p_c1   = p_c0;
        p_s1   = p_s0;
        p_s2   = p_s0;
        p_c    = p_c0;
        p_s    = p_s0;
        p_den  = '0;
        p_dvd  = '0;
        p_mag  = '0;
        p_num  = (NUM_W'(i_timer_freq) << 14) - (NUM_W'(i_timer_freq) << 10);
        case (r_in.cmd)
            CMD_TICK: begin
                if (m_ok) begin
                    if (r_stop[idx] &&
                        ({1'b0, p_c0} + {1'b0, near_fx}) >= {1'b0, init_fx}) begin
                        p_run = 1'b0;
                        p_c0  = init_fx;
                        p_s0  = '0;
                    end
                    p_c1 = p_c0;
                    p_s1 = p_s0;
                    if (r_wdir[idx] == r_cdir[idx]) begin
                        if (p_c0 >= init_fx) begin
                            p_c1 = init_fx;
                            p_s1 = '0;
                        end
                        p_s2 = (p_s1 == STEP_MAX) ? p_s1 : p_s1 + 1'b1;
                        if (r_tgt[idx] >= init_fx &&
                            ({1'b0, p_c1} + {1'b0, near_fx}) >= {1'b0, init_fx}) begin
                            p_mode = M_KEEP;
                            p_c    = r_tgt[idx];
                            p_s    = '0;
                        end else if (p_c1 > r_tgt[idx]) begin
                            p_mode = M_ACC;
                            p_c    = p_c1;
                            p_s    = p_s2;
                            p_den  = DEN_W'({p_s2, 2'b01});
                        end else if (p_s1 != '0) begin
                            p_mode = M_DEC;
                            p_c    = p_c1;
                            p_s    = p_s1 - 1'b1;
                            p_den  = DEN_W'({p_s1, 2'b00}) - 1'b1;
                        end else begin
                            p_mode = M_KEEP;
                            p_c    = p_c1;
                            p_s    = p_s1;
                        end
                    end else begin
                        if (({1'b0, p_c0} + {1'b0, near_fx}) > {1'b0, init_fx}) begin
                            p_mode = M_KEEP;
                            p_dir  = r_wdir[idx];
                            p_c    = init_fx;
                            p_s    = '0;
                        end else if (p_s0 != '0) begin
                            p_mode = M_DEC;
                            p_c    = p_c0;
                            p_s    = p_s0 - 1'b1;
                            p_den  = DEN_W'({p_s0, 2'b00}) - 1'b1;
                        end else begin
                            p_mode = M_KEEP;
                            p_c    = p_c0;
                            p_s    = p_s0;
                        end
                    end
                    p_dvd = DVW'({p_c, 1'b0});
                end
            end
            CMD_SET: begin
                if (m_ok && r_en) begin
                    if (r_in.rpm == '0) begin
                        p_mode = M_SETZ;
                    end else begin
                        p_mode = M_SET;
                        p_dir  = r_in.rpm[RPM_W-1];
                        p_mag  = r_in.rpm[RPM_W-1] ? RPM_W'(-r_in.rpm) : RPM_W'(r_in.rpm);
                        p_den  = DEN_W'(i_steps_per_rev) * DEN_W'(p_mag);
                        p_dvd  = DVW'(p_num) << FRAC_BITS;
                    end
                end
            end
            CMD_ENABLE: begin
                p_mode = M_EN;
            end
            default: begin
                p_mode = M_DIS;
            end
        endcase
    end

    // One restoring divide step per cycle.
    logic [RW-1:0] d_sh, d_diff;
    assign d_sh   = {r_rem[RW-2:0], r_quo[DVW-1]};
    assign d_diff = d_sh - {1'b0, r_den};

    // Final values of the addressed motor.
    logic [PW:0]    f_sum;
    logic [PW:0]    f_c;
    logic [STEP_W-1:0] f_s;
    logic           f_run;
    logic [PW-1:0]  f_tgt;
    logic           f_tick;

    always_comb begin
        f_tick = (r_mode == M_KEEP) || (r_mode == M_ACC) || (r_mode == M_DEC);
        case (r_mode)
            M_ACC:   f_sum = {1'b0, r_c} - {1'b0, r_quo[PW-1:0]};
            M_DEC:   f_sum = {1'b0, r_c} + {1'b0, r_quo[PW-1:0]};
            default: f_sum = {1'b0, r_c};
        endcase
        f_c   = f_sum;
        f_s   = r_s;
        f_run = r_run_w;
        if (f_c < {1'b0, min_fx}) begin
            f_c = {1'b0, min_fx};
        end
        if (f_c > {1'b0, max_fx}) begin
            f_run = 1'b0;
            f_c   = {1'b0, init_fx};
            f_s   = '0;
        end
        f_tgt = (r_quo[DVW-1:PW] != '0) ? {PW{1'b1}} : r_quo[PW-1:0];
    end

    // Status of the addressed motor as reported.
    t_out n_out;
    always_comb begin
        n_out.motor_out  = r_in.motor;
        n_out.timer_run  = 1'b0;
        n_out.period     = '0;
        n_out.dir_level  = 1'b0;
        n_out.drivers_on = (r_mode == M_EN) ? 1'b1 : (r_mode == M_DIS) ? 1'b0 : r_en;
        if (m_ok) begin
            if (f_tick) begin
                n_out.timer_run = f_run;
                n_out.period    = f_c[FRAC_BITS +: PER_W];
                n_out.dir_level = ~r_dir_w;
            end else begin
                n_out.timer_run = (r_mode == M_SET) ? 1'b1 :
                                  (r_mode == M_DIS) ? 1'b0 : r_run[idx];
                n_out.period    = (r_mode == M_DIS) ? init_fx[FRAC_BITS +: PER_W] :
                                  r_cur[idx][FRAC_BITS +: PER_W];
                n_out.dir_level = ~r_cdir[idx];
            end
        end
    end

    // Item, work and divider registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in <= i_in_data;
        end
        if (i_ctl.prep) begin
            r_mode  <= p_mode;
            r_c     <= p_c;
            r_s     <= p_s;
            r_run_w <= p_run;
            r_dir_w <= p_dir;
            r_den   <= p_den;
            r_rem   <= '0;
            r_quo   <= p_dvd;
        end else if (i_ctl.div_step) begin
            if (d_sh >= {1'b0, r_den}) begin
                r_rem <= d_diff;
                r_quo <= {r_quo[DVW-2:0], 1'b1};
            end else begin
                r_rem <= d_sh;
                r_quo <= {r_quo[DVW-2:0], 1'b0};
            end
        end
        if (i_ctl.commit) begin
            r_out <= n_out;
        end
    end

    // Motor state update at commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_cur[k]  <= PW'(IP_RST) << FRAC_BITS;
                r_tgt[k]  <= '0;
                r_step[k] <= '0;
            end
            r_cdir <= '1;
            r_wdir <= '1;
            r_stop <= '0;
            r_run  <= '0;
            r_en   <= 1'b0;
        end else if (i_ctl.commit) begin
            case (r_mode)
                M_KEEP, M_ACC, M_DEC: begin
                    r_cur[idx]  <= f_c[PW-1:0];
                    r_step[idx] <= f_s;
                    r_run[idx]  <= f_run;
                    r_cdir[idx] <= r_dir_w;
                end
                M_SET: begin
                    r_stop[idx] <= 1'b0;
                    r_wdir[idx] <= r_dir_w;
                    r_tgt[idx]  <= f_tgt;
                    r_run[idx]  <= 1'b1;
                end
                M_SETZ: begin
                    r_stop[idx] <= 1'b1;
                    r_tgt[idx]  <= init_fx;
                end
                M_EN: begin
                    r_en <= 1'b1;
                end
                M_DIS: begin
                    for (int k = 0; k < MOTOR_COUNT; k++) begin
                        r_cur[k]  <= init_fx;
                        r_step[k] <= '0;
                    end
                    r_run <= '0;
                    r_en  <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register; a held result frees when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.need_div = (p_mode == M_ACC) || (p_mode == M_DEC) || (p_mode == M_SET);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== src/srg_ctrl.sv =====
`include "assert_macros.svh"

module srg_ctrl import srg_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam int DVW = NUM_W + FRAC_BITS;
    localparam int CW  = $clog2(DVW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    // Next state and divide step count.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_cnt   = '0;
                n_state = i_sts.need_div ? S_DIV : S_DONE;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(DVW - 1)) begin
                    n_state = S_DONE;
                end
            end
            default: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Commands to the datapath.
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_ctl.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_ctl.prep      = (r_state == S_PREP);
    assign o_ctl.div_step  = (r_state == S_DIV);
    assign o_ctl.commit    = (r_state == S_DONE) && i_sts.out_free;

    `SRG_ASSERT(a_accept_to_prep, i_clk, i_rst_n, (r_state == S_IDLE && i_in_valid) |=> (r_state == S_PREP))
    `SRG_ASSERT(a_div_length, i_clk, i_rst_n, (r_state == S_DIV && r_cnt == CW'(DVW - 1)) |=> (r_state == S_DONE))
    `SRG_ASSERT(a_hold_result, i_clk, i_rst_n, (r_state == S_DONE && !i_sts.out_free) |=> (r_state == S_DONE))

endmodule

// ===== src/stepper_ramp_generator.sv =====
// Tick and set items that divide go from transfer through the prepare, divide and done states
// to the output register; all other items skip the divide state.
// Throughput: one item at a time, set by the bit-serial divider (one quotient bit a cycle).
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low): registers to their defaults, periods to 25000 counts,
// drivers off, all timers stopped.
module stepper_ramp_generator import srg_pkg::*; #(
    parameter int MOTOR_COUNT = 3,
    parameter int FRAC_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TF_W-1:0]  r_timer_freq;
    logic [SPR_W-1:0] r_steps_per_rev;
    logic [IP_W-1:0]  r_init_period;
    t_ctl ctl;
    t_sts sts;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_freq    <= TF_RST;
            r_steps_per_rev <= SPR_RST;
            r_init_period   <= IP_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_TF:   r_timer_freq    <= pwdata[TF_W-1:0];
                REG_SPR:  r_steps_per_rev <= pwdata[SPR_W-1:0];
                REG_INIT: r_init_period   <= pwdata[IP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[3:2])
            REG_TF:   prdata = 32'(r_timer_freq);
            REG_SPR:  prdata = 32'(r_steps_per_rev);
            REG_INIT: prdata = 32'(r_init_period);
            default:  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    srg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    srg_datapath #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_data       (i_in_data),
        .i_out_stall     (i_out_stall),
        .i_timer_freq    (r_timer_freq),
        .i_steps_per_rev (r_steps_per_rev),
        .i_init_period   (r_init_period),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_out_data      (o_out_data)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import srg_pkg::*;

    localparam int NUM_MOTORS   = 3;
    localparam int FRAC         = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [63:0] PERIOD_SAT = (64'd1 << 40) - 64'd1;
    localparam logic [23:0] RAMP_SAT   = STEP_MAX;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stepper_ramp_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the block's registers and per-motor ramp state.
    logic [26:0] sh_freq;
    logic [15:0] sh_spr;
    logic [15:0] sh_init;
    logic [63:0] per_now [NUM_MOTORS];
    logic [63:0] per_goal [NUM_MOTORS];
    logic [23:0] ramp_n [NUM_MOTORS];
    bit          dir_now [NUM_MOTORS];
    bit          dir_goal [NUM_MOTORS];
    bit          halt_req [NUM_MOTORS];
    bit          timer_on [NUM_MOTORS];
    bit          drv_on;

    t_in  pending_cmds [$];
    t_out status_due [$];
    int   fail_count;
    bit   calm;
    int   send_gap;
    int   sink_gap;
    int   idle_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] to_fix(logic [63:0] whole);
        return whole << FRAC;
    endfunction

    // Target period from a speed magnitude, truncating serial division.
    function automatic logic [63:0] target_from_speed(logic [31:0] mag);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] r;
        num = 64'(sh_freq) * 64'd15360;
        den = 64'(sh_spr) * 64'(mag);
        if (den == 0) return PERIOD_SAT;
        q = num / den;
        r = num % den;
        if (q > PERIOD_SAT) return PERIOD_SAT;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
            if (q > PERIOD_SAT) return PERIOD_SAT;
        end
        return q;
    endfunction

    function automatic void slow_down(int m);
        if (ramp_n[m] > 0) begin
            per_now[m] = per_now[m] + (2 * per_now[m]) / (4 * 64'(ramp_n[m]) - 1);
            ramp_n[m]  = ramp_n[m] - 1;
        end
    endfunction

    // One step tick of the linear acceleration ramp.
    function automatic void step_ramp(int m);
        logic [63:0] base;
        logic [63:0] near;
        base = to_fix(64'(sh_init));
        near = to_fix(64'(NEAR_CNT));
        if (halt_req[m] && per_now[m] + near >= base) begin
            timer_on[m] = 0;
            per_now[m]  = base;
            ramp_n[m]   = '0;
        end
        if (dir_goal[m] == dir_now[m]) begin
            if (per_now[m] >= base) begin
                per_now[m] = base;
                ramp_n[m]  = '0;
            end
            if (per_goal[m] >= base && per_now[m] + near >= base) begin
                per_now[m] = per_goal[m];
                ramp_n[m]  = '0;
            end else if (per_now[m] > per_goal[m]) begin
                if (ramp_n[m] < RAMP_SAT) ramp_n[m] = ramp_n[m] + 1;
                per_now[m] = per_now[m] - (2 * per_now[m]) / (4 * 64'(ramp_n[m]) + 1);
            end else begin
                slow_down(m);
            end
        end else begin
            if (per_now[m] + near > base) begin
                dir_now[m] = dir_goal[m];
                per_now[m] = base;
                ramp_n[m]  = '0;
            end else begin
                slow_down(m);
            end
        end
        if (per_now[m] < to_fix(64'(MIN_CNT))) per_now[m] = to_fix(64'(MIN_CNT));
        if (per_now[m] > to_fix(64'(MAX_CNT))) begin
            timer_on[m] = 0;
            per_now[m]  = base;
            ramp_n[m]   = '0;
        end
    endfunction

    function automatic void take_speed(int m, logic signed [19:0] rpm);
        int v;
        if (!drv_on) return;
        v = int'(rpm);
        if (v == 0) begin
            halt_req[m] = 1;
            per_goal[m] = to_fix(64'(sh_init));
            return;
        end
        halt_req[m] = 0;
        dir_goal[m] = (v < 0);
        per_goal[m] = target_from_speed(v < 0 ? 32'(-v) : 32'(v));
        timer_on[m] = 1;
    endfunction

    // Applies one command and returns the status the block reports.
    function automatic t_out motor_status(t_in it);
        t_out res;
        int   m;
        bit   ok;
        m  = int'(it.motor);
        ok = m < NUM_MOTORS;
        case (it.cmd)
            CMD_TICK: begin
                if (ok) step_ramp(m);
            end
            CMD_SET: begin
                if (ok) take_speed(m, it.rpm);
            end
            CMD_ENABLE: begin
                drv_on = 1;
            end
            default: begin
                for (int k = 0; k < NUM_MOTORS; k++) begin
                    timer_on[k] = 0;
                    per_now[k]  = to_fix(64'(sh_init));
                    ramp_n[k]   = '0;
                end
                drv_on = 0;
            end
        endcase
        res.motor_out  = it.motor;
        res.timer_run  = ok ? timer_on[m] : 1'b0;
        res.period     = ok ? per_now[m][FRAC +: 16] : 16'd0;
        res.dir_level  = ok ? ~dir_now[m] : 1'b0;
        res.drivers_on = drv_on;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Input driver: takes commands from the pending queue, with random gaps.
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) status_due.push_back(motor_status(i_in_data));
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap   <= $urandom_range(0, 5);
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                i_in_data  <= pending_cmds.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output stall generator.
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_gap    <= 0;
        end else if (sink_gap > 0) begin
            sink_gap    <= sink_gap - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_gap    <= $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: checks each status transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                report_mismatch("unexpected status", 1, 0);
            end else begin
                want = status_due.pop_front();
                if (o_out_data.motor_out != want.motor_out)
                    report_mismatch("motor_out", o_out_data.motor_out, want.motor_out);
                if (o_out_data.timer_run != want.timer_run)
                    report_mismatch("timer_run", o_out_data.timer_run, want.timer_run);
                if (o_out_data.period != want.period)
                    report_mismatch("period", o_out_data.period, want.period);
                if (o_out_data.dir_level != want.dir_level)
                    report_mismatch("dir_level", o_out_data.dir_level, want.dir_level);
                if (o_out_data.drivers_on != want.drivers_on)
                    report_mismatch("drivers_on", o_out_data.drivers_on, want.drivers_on);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TF:  sh_freq = value[26:0];
            REG_SPR: sh_spr  = value[15:0];
            default: sh_init = value[15:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || i_in_valid || status_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_cmd(logic [1:0] cmd, logic [1:0] motor, logic [19:0] rpm);
        t_in it;
        it.cmd   = cmd;
        it.motor = motor;
        it.rpm   = rpm;
        pending_cmds.push_back(it);
    endtask

    function automatic logic [19:0] pick_speed();
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return 20'($urandom_range(1, 8000));
            2: return -20'($urandom_range(1, 8000));
            default: return 20'($urandom_range(0, 1) ? 20'h7FFFF : 20'h80000);
        endcase
    endfunction

    // Random traffic: mostly a speed command followed by a run of ticks.
    task automatic add_random(int count);
        int n;
        int m;
        n = 0;
        while (n < count) begin
            case ($urandom_range(0, 19))
                0: begin
                    add_cmd(CMD_DISABLE, 2'($urandom), 20'($urandom));
                    n++;
                end
                1, 2: begin
                    add_cmd(2'($urandom), 2'($urandom), 20'($urandom));
                    n++;
                end
                default: begin
                    m = $urandom_range(0, 2);
                    if ($urandom_range(0, 3) == 0) begin
                        add_cmd(CMD_ENABLE, 2'($urandom), 20'($urandom));
                        n++;
                    end
                    add_cmd(CMD_SET, 2'(m), ($urandom_range(0, 7) == 0) ? 20'd0 : pick_speed());
                    n++;
                    repeat ($urandom_range(10, 60)) begin
                        add_cmd(CMD_TICK, ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'(m),
                                20'($urandom));
                        n++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        fail_count  = 0;
        calm        = 0;
        send_gap    = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        sh_freq     = TF_RST;
        sh_spr      = SPR_RST;
        sh_init     = IP_RST;
        for (int k = 0; k < NUM_MOTORS; k++) begin
            per_now[k]  = to_fix(64'(IP_RST));
            per_goal[k] = '0;
            ramp_n[k]   = '0;
            dir_now[k]  = 1;
            dir_goal[k] = 1;
            halt_req[k] = 0;
            timer_on[k] = 0;
        end
        drv_on = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: set while off, enable, extreme speeds, stop, reversal, bad motor.
        add_cmd(CMD_SET, 2'd0, 20'd5000);
        add_cmd(CMD_TICK, 2'd0, 20'd0);
        add_cmd(CMD_ENABLE, 2'd0, 20'd0);
        add_cmd(CMD_SET, 2'd0, 20'h7FFFF);
        add_cmd(CMD_SET, 2'd1, 20'h80000);
        add_cmd(CMD_SET, 2'd2, 20'd1);
        repeat (4) add_cmd(CMD_TICK, 2'd0, 20'h00000);
        repeat (3) add_cmd(CMD_TICK, 2'd2, 20'hFFFFF);
        add_cmd(CMD_TICK, 2'd1, 20'd0);
        add_cmd(CMD_SET, 2'd1, 20'd0);
        add_cmd(CMD_TICK, 2'd1, 20'd0);
        add_cmd(CMD_SET, 2'd0, -20'd15360);
        repeat (3) add_cmd(CMD_TICK, 2'd0, 20'd0);
        add_cmd(CMD_SET, 2'd3, 20'd100);
        add_cmd(CMD_TICK, 2'd3, 20'd0);
        add_cmd(CMD_DISABLE, 2'd3, 20'hFFFFF);
        add_cmd(CMD_TICK, 2'd0, 20'd0);
        add_random(300);
        wait_idle();

        // Fast timer, coarse motor, slowest start.
        reg_write(REG_TF, 32'd100000000);
        reg_write(REG_SPR, 32'd1);
        reg_write(REG_INIT, 32'd65535);
        add_random(300);
        wait_idle();

        // Slow timer, fine motor, fastest start.
        reg_write(REG_TF, 32'd1);
        reg_write(REG_SPR, 32'd65535);
        reg_write(REG_INIT, 32'd101);
        add_random(300);
        wait_idle();

        // Random mid-range settings, then a final run without idling.
        reg_write(REG_TF, 32'($urandom_range(1000, 100000000)));
        reg_write(REG_SPR, 32'($urandom_range(1, 65535)));
        reg_write(REG_INIT, 32'($urandom_range(101, 65535)));
        add_random(350);
        while (pending_cmds.size() > 100) @(posedge i_clk);
        calm = 1;
        wait_idle();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== stepper_ramp_generator.f =====
+incdir+src
src/srg_pkg.sv
src/srg_datapath.sv
src/srg_ctrl.sv
src/stepper_ramp_generator.sv
test/tb_top.sv
